[rtl/neighbor_table_next_hop_select_unit_defines.svh]
// Assertion macros shared by the neighbor table checker.
`ifndef NEIGHBOR_TABLE_NEXT_HOP_SELECT_UNIT_DEFINES_SVH
`define NEIGHBOR_TABLE_NEXT_HOP_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NTHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("neighbor table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NTHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("neighbor table check failed");

`endif

[rtl/nths_pkg.sv]
// Types and constants shared by the neighbor table and next hop selection unit.
package nths_pkg;

    localparam int ADDR_W   = 16;
    localparam int ENERGY_W = 16;
    localparam int TRUST_W  = 10;
    localparam int SLOT_W   = 4;
    localparam int SCORE_W  = TRUST_W + ENERGY_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TRUST_W-1:0] TRUST_FULL = 10'd1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRUST_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRUST_BONUS = 2'd2;

    localparam logic [TRUST_W-1:0]  RST_TRUST_THR   = 10'd500;
    localparam logic [ENERGY_W-1:0] RST_ENERGY_THR  = 16'd10;
    localparam logic [TRUST_W-1:0]  RST_TRUST_BONUS = 10'd10;

    typedef struct packed {
        logic [ADDR_W-1:0]   neighbor_addr;
        logic [ENERGY_W-1:0] neighbor_energy;
        logic [TRUST_W-1:0]  neighbor_trust;
    } t_hello;

    typedef struct packed {
        logic                stored;
        logic [SLOT_W-1:0]   entry_slot;
        logic                hop_found;
        logic [SLOT_W-1:0]   hop_slot;
        logic [ADDR_W-1:0]   hop_addr;
    } t_hop_result;

    // Thresholds seen by every cell.
    typedef struct packed {
        logic [TRUST_W-1:0]  trust_thr;
        logic [ENERGY_W-1:0] energy_thr;
    } t_hop_cfg;

    // Token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   addr;
        logic [ENERGY_W-1:0] energy;
        logic [TRUST_W-1:0]  trust;
        logic                stored;
        logic                added;
        logic [SLOT_W-1:0]   slot;
        logic                found;
        logic [SCORE_W-1:0]  lead_score;
        logic [SLOT_W-1:0]   best_slot;
        logic [ADDR_W-1:0]   best_addr;
    } t_hop_pkt;

endpackage

[rtl/nths_cell.sv]
// One table slot: holds an entry, updates it and scores it as the token passes.
module nths_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nths_pkg::t_hop_pkt i_pkt,
    input  logic [CW-1:0]      i_used,
    input  nths_pkg::t_hop_cfg i_cfg,
    output nths_pkg::t_hop_pkt o_pkt
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [nths_pkg::SLOT_W-1:0] SLOT_C = nths_pkg::SLOT_W'(IDX);

    logic [nths_pkg::ADDR_W-1:0]   r_addr;
    logic [nths_pkg::ENERGY_W-1:0] r_energy;
    logic [nths_pkg::TRUST_W-1:0]  r_trust;
    logic                          r_valid;
    nths_pkg::t_hop_pkt            r_pkt;
    nths_pkg::t_hop_pkt            n_pkt;

    logic                          in_use;
    logic                          hit;
    logic                          app;
    logic                          wr;
    logic [nths_pkg::ENERGY_W-1:0] cur_e;
    logic [nths_pkg::TRUST_W-1:0]  cur_t;
    logic [nths_pkg::SCORE_W-1:0]  score;
    logic                          take;

    always_comb begin
        in_use = IDX_C < i_used;
        hit    = i_pkt.valid && !i_pkt.stored && in_use && (r_addr == i_pkt.addr);
        // The first free slot takes the hello when no used slot matched.
        app    = i_pkt.valid && !i_pkt.stored && (IDX_C == i_used);
        wr     = hit || app;
        cur_e  = wr ? i_pkt.energy : r_energy;
        cur_t  = wr ? i_pkt.trust : r_trust;
        score  = nths_pkg::SCORE_W'(cur_t) * nths_pkg::SCORE_W'(cur_e);
        take   = (in_use || app) && (cur_t > i_cfg.trust_thr)
                 && (cur_e > i_cfg.energy_thr)
                 && (!i_pkt.found || (score > i_pkt.lead_score));

        n_pkt = i_pkt;
        if (wr) begin
            n_pkt.stored = 1'b1;
            n_pkt.added  = app;
            n_pkt.slot   = SLOT_C;
        end
        if (take) begin
            n_pkt.found      = 1'b1;
            n_pkt.lead_score = score;
            n_pkt.best_slot  = SLOT_C;
            n_pkt.best_addr  = wr ? i_pkt.addr : r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_addr   <= i_pkt.addr;
            r_energy <= i_pkt.energy;
            r_trust  <= i_pkt.trust;
        end
        r_pkt <= n_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_pkt.valid;
        end
    end

    always_comb begin
        o_pkt       = r_pkt;
        o_pkt.valid = r_valid;
    end

endmodule

[rtl/neighbor_table_next_hop_select_unit.sv]
// Top level of the neighbor table with next hop selection.
// A hello is taken when start is high and busy is low. It then walks a row of
// TABLE_DEPTH cells, one cell per cycle; each cell holds one table slot, updates
// it on an address hit or as the first free slot, and keeps the best trust times
// energy score seen so far. The result is strobed on o_valid for one cycle from
// the last cell's output register, and is taken at the edge that ends that cycle,
// as the receiver cannot stall the block. busy drops at that same edge, so a new
// hello is not accepted until the previous result is out.
module neighbor_table_next_hop_select_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  nths_pkg::t_hello                    i_hello,
    input  logic                                i_cfg_we,
    input  logic [nths_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [nths_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    output nths_pkg::t_hop_result               o_result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [nths_pkg::TRUST_W-1:0]  r_trust_thr;
    logic [nths_pkg::ENERGY_W-1:0] r_energy_thr;
    logic [nths_pkg::TRUST_W-1:0]  r_bonus;
    logic [CW-1:0]                 r_used;
    logic                          r_busy;
    logic                          r_head_valid;
    nths_pkg::t_hop_pkt            r_head;
    nths_pkg::t_hop_pkt            w_pkt [TABLE_DEPTH+1];
    nths_pkg::t_hop_cfg            w_cfg;

    logic                          accept;
    logic [nths_pkg::TRUST_W:0]    trust_sum;
    logic [nths_pkg::TRUST_W-1:0]  trust_new;
    nths_pkg::t_hop_pkt            last;

    assign accept    = start && !r_busy;
    assign trust_sum = {1'b0, i_hello.neighbor_trust} + {1'b0, r_bonus};
    assign trust_new = (trust_sum > {1'b0, nths_pkg::TRUST_FULL})
                       ? nths_pkg::TRUST_FULL : trust_sum[nths_pkg::TRUST_W-1:0];

    assign w_cfg.trust_thr  = r_trust_thr;
    assign w_cfg.energy_thr = r_energy_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trust_thr  <= nths_pkg::RST_TRUST_THR;
            r_energy_thr <= nths_pkg::RST_ENERGY_THR;
            r_bonus      <= nths_pkg::RST_TRUST_BONUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nths_pkg::REG_TRUST_THR:
                    r_trust_thr <= i_cfg_data[nths_pkg::TRUST_W-1:0];
                nths_pkg::REG_ENERGY_THR:
                    r_energy_thr <= i_cfg_data[nths_pkg::ENERGY_W-1:0];
                nths_pkg::REG_TRUST_BONUS:
                    r_bonus <= i_cfg_data[nths_pkg::TRUST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The head register starts a fresh token with empty search and score fields.
    always_ff @(posedge i_clk) begin
        r_head.addr       <= i_hello.neighbor_addr;
        r_head.energy     <= i_hello.neighbor_energy;
        r_head.trust      <= trust_new;
        r_head.stored     <= 1'b0;
        r_head.added      <= 1'b0;
        r_head.slot       <= '0;
        r_head.found      <= 1'b0;
        r_head.lead_score <= '0;
        r_head.best_slot  <= '0;
        r_head.best_addr  <= '0;
        r_head.valid      <= 1'b0;
    end

    always_comb begin
        w_pkt[0]       = r_head;
        w_pkt[0].valid = r_head_valid;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        nths_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pkt   (w_pkt[g]),
            .i_used  (r_used),
            .i_cfg   (w_cfg),
            .o_pkt   (w_pkt[g+1])
        );
    end

    assign last = w_pkt[TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_head_valid <= 1'b0;
            r_used       <= '0;
        end else begin
            r_head_valid <= accept;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last.valid) begin
                r_busy <= 1'b0;
            end
            if (last.valid && last.added) begin
                r_used <= r_used + CW'(1);
            end
        end
    end

    assign busy    = r_busy;
    assign o_valid = last.valid;

    always_comb begin
        o_result.stored     = last.stored;
        o_result.entry_slot = last.slot;
        o_result.hop_found  = last.found;
        o_result.hop_slot   = last.best_slot;
        o_result.hop_addr   = last.best_addr;
    end

endmodule

[rtl/nths_checker.sv]
// Port-level checker for the neighbor table unit and its bind.
`include "neighbor_table_next_hop_select_unit_defines.svh"

module nths_port_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input nths_pkg::t_hop_result o_result
);

    logic result_dropped;
    logic result_no_hop;
    logic hop_cleared;

    assign result_dropped = o_valid && !o_result.stored;
    assign result_no_hop  = o_valid && !o_result.hop_found;
    assign hop_cleared    = (o_result.hop_slot == '0) && (o_result.hop_addr == '0);

    // A transfer in always raises busy until its result is out.
    `NTHS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)
    `NTHS_ASSERT_NOW(a_result_while_busy, i_clk, i_rst_n, o_valid, busy)
    `NTHS_ASSERT_NEXT(a_result_frees, i_clk, i_rst_n, o_valid, !busy && !o_valid)
    `NTHS_ASSERT_NOW(a_drop_slot_zero, i_clk, i_rst_n, result_dropped, o_result.entry_slot == '0)
    `NTHS_ASSERT_NOW(a_no_hop_zero, i_clk, i_rst_n, result_no_hop, hop_cleared)

endmodule

bind neighbor_table_next_hop_select_unit nths_port_checker u_nths_port_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

[verif/nths_checker.sv]
// Checker for the neighbor table unit: predicts each hello's next hop result and compares.
module nths_checker
    import nths_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_hello                i_hello,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_hop_result           i_result,
    output int                    o_err_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TRUST_W-1:0]  trust_thr;
    logic [ENERGY_W-1:0] energy_thr;
    logic [TRUST_W-1:0]  trust_bonus;

    logic [ADDR_W-1:0]   tbl_addr   [TABLE_DEPTH];
    logic [TRUST_W-1:0]  tbl_trust  [TABLE_DEPTH];
    logic [ENERGY_W-1:0] tbl_energy [TABLE_DEPTH];
    int unsigned         used_slots;

    t_hop_result expected_hops[$];
    int          mismatches;

    // Applies one hello to the shadow table and returns the result it must produce.
    function automatic t_hop_result next_hop_after_hello(t_hello h);
        t_hop_result r;
        logic        hit;
        logic        found;
        int unsigned slot;
        int unsigned best_slot;
        int unsigned lead_score;
        int unsigned score;
        int unsigned sum;
        hit = 1'b0;
        slot = 0;
        for (int i = 0; i < used_slots; i++) begin
            if (!hit && tbl_addr[i] == h.neighbor_addr) begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (!hit && used_slots < TABLE_DEPTH) begin
            slot = used_slots;
            tbl_addr[slot] = h.neighbor_addr;
            used_slots++;
            hit = 1'b1;
        end
        if (hit) begin
            sum = int'(h.neighbor_trust) + int'(trust_bonus);
            tbl_energy[slot] = h.neighbor_energy;
            tbl_trust[slot] = (sum > TRUST_FULL) ? TRUST_FULL : TRUST_W'(sum);
        end

        found = 1'b0;
        best_slot = 0;
        lead_score = 0;
        for (int i = 0; i < used_slots; i++) begin
            score = int'(tbl_trust[i]) * int'(tbl_energy[i]);
            // Strictly greater keeps the lower slot on equal scores.
            if (tbl_trust[i] > trust_thr && tbl_energy[i] > energy_thr &&
                (!found || score > lead_score)) begin
                found = 1'b1;
                lead_score = score;
                best_slot = i;
            end
        end

        r.stored     = hit;
        r.entry_slot = hit ? SLOT_W'(slot) : '0;
        r.hop_found  = found;
        r.hop_slot   = found ? SLOT_W'(best_slot) : '0;
        r.hop_addr   = found ? tbl_addr[best_slot] : '0;
        return r;
    endfunction

    task automatic report_field(string name, int unsigned want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_hop_result want;
        if (!i_rst_n) begin
            trust_thr   = RST_TRUST_THR;
            energy_thr  = RST_ENERGY_THR;
            trust_bonus = RST_TRUST_BONUS;
            used_slots  = 0;
            expected_hops.delete();
            mismatches  = 0;
        end else begin
            if (i_valid) begin
                if (expected_hops.size() == 0) begin
                    $error("result transfer with no hello outstanding");
                    mismatches++;
                end else begin
                    want = expected_hops.pop_front();
                    report_field("stored", want.stored, i_result.stored);
                    report_field("entry_slot", want.entry_slot, i_result.entry_slot);
                    report_field("hop_found", want.hop_found, i_result.hop_found);
                    report_field("hop_slot", want.hop_slot, i_result.hop_slot);
                    report_field("hop_addr", want.hop_addr, i_result.hop_addr);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TRUST_THR:   trust_thr   = i_cfg_data[TRUST_W-1:0];
                    REG_ENERGY_THR:  energy_thr  = i_cfg_data[ENERGY_W-1:0];
                    REG_TRUST_BONUS: trust_bonus = i_cfg_data[TRUST_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                expected_hops.push_back(next_hop_after_hello(i_hello));
        end
        o_pending   <= expected_hops.size();
        o_err_count <= mismatches;
    end

endmodule

[verif/tb_top.sv]
// Testbench top for the neighbor table unit: clock, reset, hello and register stimulus, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nths_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int PHASES        = 8;
    localparam int HELLOS_PER_PHASE = 125;
    localparam int CYCLE_LIMIT   = 500000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_hello                i_hello;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    t_hop_result           o_result;
    int                    err_count;
    int                    pending;
    int                    cycle_count;

    // Steering copies: what the stimulus knows of the table and the registers.
    logic [ADDR_W-1:0]   known_addrs[$];
    logic [TRUST_W-1:0]  cur_trust_thr;
    logic [ENERGY_W-1:0] cur_energy_thr;
    logic [TRUST_W-1:0]  cur_bonus;
    int                  burst_left;

    neighbor_table_next_hop_select_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_hello    (i_hello),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    nths_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_hello     (i_hello),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (o_valid),
        .i_result    (o_result),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[neighbor_table_next_hop_select_unit] ERROR");
        $finish;
    end

    function automatic logic is_known(logic [ADDR_W-1:0] a);
        foreach (known_addrs[i])
            if (known_addrs[i] == a) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [ADDR_W-1:0] unknown_addr();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        while (is_known(a)) a = ADDR_W'($urandom);
        return a;
    endfunction

    function automatic t_hello make_hello(logic [ADDR_W-1:0] a, int energy, int trust);
        t_hello h;
        h.neighbor_addr   = a;
        h.neighbor_energy = ENERGY_W'(energy);
        h.neighbor_trust  = TRUST_W'(trust);
        return h;
    endfunction

    // Random hello: mostly known neighbors, with some values near the thresholds or at the ends of the range.
    function automatic t_hello random_hello();
        logic [ADDR_W-1:0] a;
        int energy;
        int trust;
        if ($urandom_range(0, 99) < 85 && known_addrs.size() != 0)
            a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
        else
            a = ADDR_W'($urandom);
        case ($urandom_range(0, 9))
            0: energy = $urandom_range(0, 1) ? 65535 : 0;
            1: energy = int'(cur_energy_thr) + $urandom_range(0, 2) - 1;
            default: energy = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 9))
            0: trust = $urandom_range(1001, 1023);
            1: begin
                trust = int'(cur_trust_thr) - int'(cur_bonus) + $urandom_range(0, 2) - 1;
                if (trust < 0) trust = 0;
                if (trust > 1023) trust = 1023;
            end
            2: trust = $urandom_range(0, 1) ? 1000 : 0;
            default: trust = $urandom_range(0, 1000);
        endcase
        return make_hello(a, energy, trust);
    endfunction

    // Holds start until the transfer, then drops start and waits out the gap when one is given.
    task automatic drive_hello(t_hello h, int gap);
        i_hello <= h;
        start   <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (!is_known(h.neighbor_addr) && known_addrs.size() < TABLE_DEPTH)
            known_addrs.push_back(h.neighbor_addr);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_settings(int t_thr, int e_thr, int bonus);
        cur_trust_thr  = TRUST_W'(t_thr);
        cur_energy_thr = ENERGY_W'(e_thr);
        cur_bonus      = TRUST_W'(bonus);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TRUST_THR;
        i_cfg_data <= CFG_DATA_W'(cur_trust_thr);
        @(posedge i_clk);
        i_cfg_idx  <= REG_ENERGY_THR;
        i_cfg_data <= CFG_DATA_W'(cur_energy_thr);
        @(posedge i_clk);
        i_cfg_idx  <= REG_TRUST_BONUS;
        i_cfg_data <= CFG_DATA_W'(cur_bonus);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_hello     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        cycle_count <= 0;
        burst_left  = 0;
        cur_trust_thr  = RST_TRUST_THR;
        cur_energy_thr = RST_ENERGY_THR;
        cur_bonus      = RST_TRUST_BONUS;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings.
        drive_hello(make_hello(16'h0000, 0, 0), 0);             // stored but not eligible
        drive_hello(make_hello(16'hFFFF, 65535, 1000), 2);      // bonus clamps at full trust
        drive_hello(make_hello(16'h1234, 11, 491), 0);          // just above both thresholds
        drive_hello(make_hello(16'h1235, 10, 1023), 1);         // trust over range, energy at threshold
        drive_hello(make_hello(16'h0000, 65535, 1000), 0);      // hit; ties slot one, lower slot wins
        drive_hello(make_hello(16'h00FF, 65535, 490), 3);       // trust lands exactly on threshold
        drive_hello(make_hello(16'hA5A5, 16'h5A5A, 10'h2AA), 0);
        drive_hello(make_hello(16'h5A5A, 16'hA5A5, 10'h155), 0);
        while (known_addrs.size() < TABLE_DEPTH)
            drive_hello(make_hello(unknown_addr(), $urandom_range(0, 65535),
                                   $urandom_range(0, 1000)), pick_gap());
        drive_hello(make_hello(unknown_addr(), 65535, 1000), 0); // miss on a full table
        drive_hello(make_hello(16'h1234, 20, 600), 0);          // hit on a full table

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: write_settings(0, 0, 0);
                1: write_settings(1000, 65535, 1000);
                2: write_settings(1023, 0, 1023);
                3: write_settings(RST_TRUST_THR, RST_ENERGY_THR, RST_TRUST_BONUS);
                default: write_settings($urandom_range(0, 1000),
                                        $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                                  : $urandom_range(0, 2000),
                                        $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                                  : $urandom_range(0, 100));
            endcase
            for (int n = 0; n < HELLOS_PER_PHASE; n++)
                drive_hello(random_hello(), pick_gap());
        end

        wait_idle();
        repeat (TABLE_DEPTH + 4) @(posedge i_clk);
        if (err_count == 0 && pending == 0)
            $display("[neighbor_table_next_hop_select_unit] OK");
        else
            $display("[neighbor_table_next_hop_select_unit] ERROR");
        $finish;
    end

endmodule
